FILE: rtl/rmh_pkg.sv
`default_nettype none
package rmh_pkg;
  localparam int unsigned DefaultCapacity = 1024;
  localparam int unsigned DefaultSampleWidth = 32;
  localparam int unsigned MedianWidth = 32;
  localparam int unsigned CountWidth = 11;

  // heap selector
  localparam logic HEAP_LO = 1'b0;
  localparam logic HEAP_HI = 1'b1;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE      = 4'd0,
    OP_LOAD      = 4'd1,
    OP_TOPS_RD   = 4'd2,
    OP_TOPS_CAP  = 4'd3,
    OP_PP_SET    = 4'd4,
    OP_PUSH_SET  = 4'd5,
    OP_DN_RD     = 4'd6,
    OP_DN_CMP    = 4'd7,
    OP_UP_RD     = 4'd8,
    OP_UP_CMP    = 4'd9,
    OP_WRITE     = 4'd10,
    OP_WRITE_INC = 4'd11
  } op_t;

  typedef struct packed {
    op_t  op;
    logic heap;
  } cmd_t;

  typedef struct packed {
    logic lo_empty;
    logic x_le_lo;
    logic lo_gt_hi;
    logic hi_gt_lo;
    logic full;
    logic up_done;
    logic dn_done;
    logic pp_swap;
  } stat_t;
endpackage
`default_nettype wire

FILE: rtl/rmh_datapath.sv
`default_nettype none
module rmh_datapath #(
  parameter int unsigned CAPACITY = rmh_pkg::DefaultCapacity,
  parameter int unsigned SAMPLE_WIDTH = rmh_pkg::DefaultSampleWidth
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    sample_in,
  input  wire rmh_pkg::cmd_t                     cmd,
  output rmh_pkg::stat_t                         stat,
  output logic signed [SAMPLE_WIDTH-1:0]         median,
  output logic [rmh_pkg::CountWidth-1:0]         count
);
  import rmh_pkg::*;

  localparam int unsigned HalfDepth = (CAPACITY + 1) / 2;
  localparam int unsigned AW = (HalfDepth > 1) ? $clog2(HalfDepth) : 1;
  localparam int unsigned SW = $clog2(HalfDepth + 1);
  localparam int unsigned IW = AW + 2;

  logic signed [SAMPLE_WIDTH-1:0] lo_mem [HalfDepth];
  logic signed [SAMPLE_WIDTH-1:0] hi_mem [HalfDepth];
  logic signed [SAMPLE_WIDTH-1:0] lo_rd0, lo_rd1, hi_rd0, hi_rd1;
  logic [AW-1:0] ra0, ra1;

  logic [SW-1:0] lo_size, hi_size;
  logic signed [SAMPLE_WIDTH-1:0] lo_top, hi_top;
  logic signed [SAMPLE_WIDTH-1:0] x, a, v;
  logic [IW-1:0] idx;
  logic [SW-1:0] n;
  logic heap;
  logic swap;

  logic we;
  logic [AW-1:0] wa;
  logic signed [SAMPLE_WIDTH-1:0] wd;

  // ahead: max heap p>q, min heap p<q
  function automatic logic ahead(input logic h, input logic signed [SAMPLE_WIDTH-1:0] p,
                                 input logic signed [SAMPLE_WIDTH-1:0] q);
    ahead = (h == HEAP_LO) ? (p > q) : (p < q);
  endfunction

  // parent and children of the walk position
  logic [IW-1:0] par, lch, rch;
  assign par = (idx - 1'b1) >> 1;
  assign lch = {idx[IW-2:0], 1'b1};
  assign rch = lch + 1'b1;

  always_comb begin
    ra0 = '0;
    ra1 = '0;
    unique case (cmd.op)
      OP_UP_RD: ra0 = par[AW-1:0];
      OP_DN_RD: begin
        ra0 = lch[AW-1:0];
        ra1 = rch[AW-1:0];
      end
      default: begin
        ra0 = '0;
        ra1 = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we && heap == HEAP_LO) lo_mem[wa] <= wd;
    if (we && heap == HEAP_HI) hi_mem[wa] <= wd;
    lo_rd0 <= lo_mem[ra0];
    lo_rd1 <= lo_mem[ra1];
    hi_rd0 <= hi_mem[ra0];
    hi_rd1 <= hi_mem[ra1];
  end

  logic signed [SAMPLE_WIDTH-1:0] rd0, rd1, best_v, top_sel;
  logic l_ok, r_ok, pick_r, dn_go, up_go, swap_now;
  logic [IW-1:0] best_i;
  logic [SW-1:0] size_sel;
  assign rd0 = (heap == HEAP_LO) ? lo_rd0 : hi_rd0;
  assign rd1 = (heap == HEAP_LO) ? lo_rd1 : hi_rd1;
  assign l_ok = {{(IW-SW){1'b0}}, n} > lch;
  assign r_ok = {{(IW-SW){1'b0}}, n} > rch;
  assign pick_r = r_ok && ahead(heap, rd1, rd0);
  assign best_v = pick_r ? rd1 : rd0;
  assign best_i = pick_r ? rch : lch;
  assign dn_go = l_ok && ahead(heap, best_v, v);
  assign up_go = (idx != '0) && ahead(heap, v, rd0);

  // top of the selected heap leaves only when it sits above the new sample
  assign size_sel = (cmd.heap == HEAP_LO) ? lo_size : hi_size;
  assign top_sel = (cmd.heap == HEAP_LO) ? lo_top : hi_top;
  assign swap_now = (size_sel != '0) && ahead(cmd.heap, top_sel, x);

  always_comb begin
    we = 1'b0;
    wa = idx[AW-1:0];
    wd = v;
    unique case (cmd.op)
      OP_UP_CMP: begin
        we = up_go;
        wd = rd0;
      end
      OP_DN_CMP: begin
        we = dn_go;
        wd = best_v;
      end
      OP_WRITE, OP_WRITE_INC: we = 1'b1;
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lo_size <= '0;
      hi_size <= '0;
    end else if (cmd.op == OP_WRITE_INC) begin
      if (heap == HEAP_LO) lo_size <= lo_size + 1'b1;
      else hi_size <= hi_size + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        x <= sample_in;
        a <= sample_in;
      end
      OP_TOPS_CAP: begin
        lo_top <= lo_rd0;
        hi_top <= hi_rd0;
      end
      OP_PP_SET: begin
        heap <= cmd.heap;
        v <= x;
        idx <= '0;
        n <= size_sel;
        swap <= swap_now;
        a <= swap_now ? top_sel : x;
      end
      OP_PUSH_SET: begin
        heap <= cmd.heap;
        v <= a;
        idx <= {{(IW-SW){1'b0}}, size_sel};
      end
      OP_UP_CMP: if (up_go) idx <= par;
      OP_DN_CMP: if (dn_go) idx <= best_i;
      default: begin
      end
    endcase
  end

  logic [SW:0] held;
  assign held = {1'b0, lo_size} + {1'b0, hi_size};

  always_comb begin
    stat.lo_empty = (lo_size == '0);
    stat.x_le_lo = (x <= lo_top);
    stat.lo_gt_hi = (lo_size > hi_size);
    stat.hi_gt_lo = (hi_size > lo_size);
    stat.full = (held >= (SW+1)'(CAPACITY));
    stat.up_done = !up_go;
    stat.dn_done = !dn_go;
    stat.pp_swap = swap;
  end

  always_comb begin
    if (lo_size == '0 && hi_size == '0) median = '0;
    else if (lo_size >= hi_size) median = lo_top;
    else median = hi_top;
  end
  assign count = CountWidth'(held);
endmodule
`default_nettype wire

FILE: rtl/rmh_ctrl.sv
`default_nettype none
module rmh_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                drop,
  output rmh_pkg::cmd_t       cmd,
  input  wire rmh_pkg::stat_t stat
);
  import rmh_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_TRD   = 15'b000000000000010,
    S_TCAP  = 15'b000000000000100,
    S_DEC   = 15'b000000000001000,
    S_PPSET = 15'b000000000010000,
    S_PPCHK = 15'b000000000100000,
    S_DNRD  = 15'b000000001000000,
    S_DNCMP = 15'b000000010000000,
    S_DNWR  = 15'b000000100000000,
    S_PUSH  = 15'b000001000000000,
    S_UPRD  = 15'b000010000000000,
    S_UPCMP = 15'b000100000000000,
    S_UPWR  = 15'b001000000000000,
    S_RRD   = 15'b010000000000000,
    S_RCAP  = 15'b100000000000000
  } state_t;

  state_t state, state_next;
  logic ph, ph_next;     // heap that the next set-up works on
  logic drop_next;

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    state_next = state;
    ph_next = ph;
    drop_next = drop;
    cmd.op = OP_NONE;
    cmd.heap = ph;
    unique case (state)
      S_IDLE: if (in_valid && in_ready) begin
        cmd.op = OP_LOAD;
        drop_next = 1'b0;
        state_next = S_TRD;
      end
      S_TRD: begin
        cmd.op = OP_TOPS_RD;
        state_next = S_TCAP;
      end
      S_TCAP: begin
        cmd.op = OP_TOPS_CAP;
        state_next = S_DEC;
      end
      S_DEC: begin
        drop_next = stat.full;
        if (stat.full) state_next = S_IDLE;
        else if (stat.lo_empty || stat.x_le_lo) begin
          ph_next = HEAP_LO;
          state_next = stat.lo_gt_hi ? S_PPSET : S_PUSH;
        end else begin
          ph_next = HEAP_HI;
          state_next = stat.hi_gt_lo ? S_PPSET : S_PUSH;
        end
      end
      S_PPSET: begin
        cmd.op = OP_PP_SET;
        state_next = S_PPCHK;
      end
      S_PPCHK: begin
        // sift the root down only if the top was displaced; push goes to the other half
        ph_next = ~ph;
        state_next = stat.pp_swap ? S_DNRD : S_PUSH;
      end
      S_DNRD: begin
        cmd.op = OP_DN_RD;
        state_next = S_DNCMP;
      end
      S_DNCMP: begin
        cmd.op = OP_DN_CMP;
        state_next = stat.dn_done ? S_DNWR : S_DNRD;
      end
      S_DNWR: begin
        cmd.op = OP_WRITE;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        cmd.op = OP_PUSH_SET;
        state_next = S_UPRD;
      end
      S_UPRD: begin
        cmd.op = OP_UP_RD;
        state_next = S_UPCMP;
      end
      S_UPCMP: begin
        cmd.op = OP_UP_CMP;
        state_next = stat.up_done ? S_UPWR : S_UPRD;
      end
      S_UPWR: begin
        cmd.op = OP_WRITE_INC;
        state_next = S_RRD;
      end
      S_RRD: begin
        cmd.op = OP_TOPS_RD;
        state_next = S_RCAP;
      end
      S_RCAP: begin
        cmd.op = OP_TOPS_CAP;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ph <= HEAP_LO;
      drop <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ph <= ph_next;
      drop <= drop_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      else if (state != S_IDLE && state_next == S_IDLE) out_valid <= 1'b1;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/running_median_two_heaps.sv
`default_nettype none
// Running median over two heaps in RAM (max-heap lower half, min-heap upper half).
// Each stored sample takes one or two sift walks over the heap levels.
// One item at a time: the next input transfer waits for the output transfer.
// Reset (rst, synchronous): both heap sizes cleared; heap memory is not cleared.
module running_median_two_heaps #(
  parameter int unsigned CAPACITY = rmh_pkg::DefaultCapacity,
  parameter int unsigned SAMPLE_WIDTH = rmh_pkg::DefaultSampleWidth
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]   sample,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [rmh_pkg::MedianWidth-1:0] median_value,
  output logic [rmh_pkg::CountWidth-1:0]        sample_count,
  output logic                                  dropped
);
  import rmh_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic signed [SAMPLE_WIDTH-1:0] med;

  rmh_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .drop(dropped), .cmd, .stat
  );

  rmh_datapath #(.CAPACITY(CAPACITY), .SAMPLE_WIDTH(SAMPLE_WIDTH)) u_dp (
    .clk, .rst, .sample_in(sample), .cmd, .stat, .median(med), .count(sample_count)
  );

  // transfer the median truncated or zero-extended to the port width
  assign median_value = MedianWidth'($unsigned(med));
endmodule
`default_nettype wire

FILE: verif/tb_running_median_two_heaps.sv
`timescale 1ns / 1ps
module tb_running_median_two_heaps;
  import rmh_pkg::*;

  localparam int unsigned Capacity = 1024;
  localparam int unsigned HalfDepth = (Capacity + 1) / 2;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned RandomItems = 1730;
  localparam int unsigned LongHoldCycles = 400;

  typedef struct packed {
    logic signed [MedianWidth-1:0] median;
    logic [CountWidth-1:0]         count;
    logic                          drop;
  } median_result_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] sample;
  logic out_valid;
  logic out_ready;
  logic signed [MedianWidth-1:0] median_value;
  logic [CountWidth-1:0] sample_count;
  logic dropped;

  running_median_two_heaps u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .median_value(median_value), .sample_count(sample_count), .dropped(dropped)
  );

  // Pending samples, filled up front; results still owed by the block.
  logic signed [31:0] pending_samples[$];
  median_result_t median_due[$];

  // Shadow copy of the two halves: index HEAP_LO is the max-heap, HEAP_HI the min-heap.
  logic signed [31:0] halves[2][HalfDepth];
  int unsigned half_size[2];

  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned got_count;
  int unsigned drop_count;
  int unsigned stall_cycles;
  int unsigned hold_left;
  bit long_hold_done;

  // True when a must sit above b in heap h.
  function automatic bit sits_above(logic h, logic signed [31:0] a, logic signed [31:0] b);
    return (h == HEAP_LO) ? (a > b) : (a < b);
  endfunction

  function automatic void heap_insert(logic h, logic signed [31:0] v);
    int unsigned i;
    int unsigned p;
    logic signed [31:0] t;
    if (half_size[h] >= HalfDepth) return;
    i = half_size[h];
    halves[h][i] = v;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!sits_above(h, halves[h][i], halves[h][p])) break;
      t = halves[h][i];
      halves[h][i] = halves[h][p];
      halves[h][p] = t;
      i = p;
    end
    half_size[h]++;
  endfunction

  // Push v and pop the top in one go; return what leaves the heap.
  function automatic logic signed [31:0] heap_swap_top(logic h, logic signed [31:0] v);
    int unsigned i;
    int unsigned l;
    int unsigned best;
    int unsigned n;
    logic signed [31:0] top;
    logic signed [31:0] t;
    n = half_size[h];
    if (n == 0 || !sits_above(h, halves[h][0], v)) return v;
    top = halves[h][0];
    halves[h][0] = v;
    i = 0;
    forever begin
      l = 2 * i + 1;
      best = i;
      if (l < n && sits_above(h, halves[h][l], halves[h][best])) best = l;
      if (l + 1 < n && sits_above(h, halves[h][l + 1], halves[h][best])) best = l + 1;
      if (best == i) break;
      t = halves[h][i];
      halves[h][i] = halves[h][best];
      halves[h][best] = t;
      i = best;
    end
    return top;
  endfunction

  // Fold one sample into the shadow halves and return the median report.
  function automatic median_result_t median_after(logic signed [31:0] x);
    median_result_t r;
    r.drop = 1'b0;
    if (half_size[HEAP_LO] + half_size[HEAP_HI] >= Capacity) begin
      r.drop = 1'b1;
    end else if (half_size[HEAP_LO] == 0 || x <= halves[HEAP_LO][0]) begin
      // ties land in the lower half
      if (half_size[HEAP_LO] > half_size[HEAP_HI]) begin
        heap_insert(HEAP_HI, heap_swap_top(HEAP_LO, x));
      end else begin
        heap_insert(HEAP_LO, x);
      end
    end else begin
      if (half_size[HEAP_HI] > half_size[HEAP_LO]) begin
        heap_insert(HEAP_LO, heap_swap_top(HEAP_HI, x));
      end else begin
        heap_insert(HEAP_HI, x);
      end
    end
    if (half_size[HEAP_LO] == 0 && half_size[HEAP_HI] == 0) r.median = '0;
    else if (half_size[HEAP_LO] >= half_size[HEAP_HI]) r.median = halves[HEAP_LO][0];
    else r.median = halves[HEAP_HI][0];
    r.count = CountWidth'(half_size[HEAP_LO] + half_size[HEAP_HI]);
    return r;
  endfunction

  // Append one sample to the pending queue.
  function automatic void queue_sample(logic signed [31:0] v);
    pending_samples = {pending_samples, v};
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch on result %0d: %s got %0d want %0d", got_count, what, got, want);
    fail_count++;
  endtask

  // Idle phase follows progress: sender 26/receiver 50, then swapped, then none.
  function automatic int unsigned idle_phase();
    if (sent_count < 600) return 0;
    if (sent_count < 1200) return 1;
    return 2;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Directed samples first, then random ones.
  initial begin
    logic signed [31:0] v;
    rst = 1'b1;
    fail_count = 0;
    half_size[HEAP_LO] = 0;
    half_size[HEAP_HI] = 0;
    // extremes, zero, minus one, ties and the rebalancing moves both ways
    queue_sample(32'sh8000_0000);
    queue_sample(32'sh7fff_ffff);
    queue_sample(32'sh0000_0000);
    queue_sample(-32'sd1);
    queue_sample(-32'sd1);
    queue_sample(-32'sd1);
    queue_sample(32'sh7fff_ffff);
    queue_sample(32'sh7fff_ffff);
    queue_sample(32'sh8000_0000);
    queue_sample(32'sh8000_0000);
    queue_sample(32'sh8000_0000);
    queue_sample(32'sd5);
    queue_sample(32'sd5);
    queue_sample(32'sd6);
    queue_sample(32'sd4);
    queue_sample(32'sh5555_5555);
    queue_sample(32'shAAAA_AAAA);
    queue_sample(32'sd0);
    queue_sample(32'sd1);
    queue_sample(-32'sd2);
    for (int i = 0; i < RandomItems; i++) begin
      case ($urandom_range(3))
        0: v = $urandom;
        1: v = $signed($urandom_range(16)) - 32'sd8;
        2: v = (i % 2) ? 32'sh7fff_fff0 + $urandom_range(15) : 32'sh8000_0000 + $urandom_range(15);
        default: v = $signed($urandom_range(2000)) - 32'sd1000;
      endcase
      queue_sample(v);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(pending_samples.size() == 0 && !in_valid && median_due.size() == 0))
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    foreach (median_due[i]) report_mismatch("missing result, expected count", 0, median_due[i].count);
    $display("covered %0d samples, %0d medians checked, %0d of them dropped at store full",
             sent_count, got_count, drop_count);
    $display("idle mixes on both channels plus one long output hold of %0d cycles",
             LongHoldCycles);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Driver: advance to the next sample once the current transfer lands.
  always @(posedge clk) begin
    logic offer;
    median_result_t due;
    if (rst) begin
      in_valid <= 1'b0;
      sample <= '0;
      sent_count <= 0;
    end else begin
      if (in_valid && in_ready) begin
        due = median_after(sample);
        median_due = {median_due, due};
        sent_count <= sent_count + 1;
      end
      if (!in_valid || in_ready) begin
        case (idle_phase())
          0: offer = ($urandom_range(99) >= 26);
          1: offer = ($urandom_range(99) >= 50);
          default: offer = 1'b1;
        endcase
        if (offer && pending_samples.size() > 0) begin
          in_valid <= 1'b1;
          sample <= pending_samples.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, with one long hold while the sender keeps offering.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!long_hold_done && sent_count >= 1300) begin
      out_ready <= 1'b0;
      hold_left <= LongHoldCycles;
      long_hold_done <= 1'b1;
    end else begin
      case (idle_phase())
        0: out_ready <= ($urandom_range(99) >= 50);
        1: out_ready <= ($urandom_range(99) >= 26);
        default: out_ready <= 1'b1;
      endcase
    end
  end

  // Monitor: check each output transfer against the oldest expectation.
  always @(posedge clk) begin
    median_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (median_due.size() == 0) begin
        report_mismatch("unexpected result, count", sample_count, -1);
      end else begin
        want = median_due.pop_front();
        if (median_value !== want.median) report_mismatch("median_value", median_value, want.median);
        if (sample_count !== want.count) report_mismatch("sample_count", sample_count, want.count);
        if (dropped !== want.drop) report_mismatch("dropped", dropped, want.drop);
        if (want.drop) drop_count++;
      end
      got_count++;
    end
  end

  // Watchdog: end the run when no transfer happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("watchdog: no transfer for %0d cycles", stall_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    got_count = 0;
    drop_count = 0;
  end
endmodule
